// ----- hw/rtl/itkf_pkg.sv -----
// ----------------------------------------------------------------------------
// itkf_pkg: shared types and constants of the IMU tilt Kalman filter
// Holds the sample and work-item layouts, the configuration record, the
// fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package itkf_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_MODE       = 3'd0;
	localparam logic [2:0] REG_Q_PITCH    = 3'd1;
	localparam logic [2:0] REG_Q_ROLL     = 3'd2;
	localparam logic [2:0] REG_Q_YAW      = 3'd3;
	localparam logic [2:0] REG_R_PITCH    = 3'd4;
	localparam logic [2:0] REG_R_ROLL     = 3'd5;
	localparam logic [2:0] REG_R_YAW      = 3'd6;
	localparam logic [2:0] REG_YAW_OFFSET = 3'd7;

	localparam logic MODE_KALMAN = 1'b0;

	localparam logic signed [20:0] DT_GAIN     = 21'sd456340;
	localparam logic signed [22:0] YAW_DT_GAIN = 23'sd2684355;
	localparam logic [24:0] ONE_Q24   = 25'd16777216;
	localparam logic [24:0] COMP_GAIN = 25'd2516582;
	localparam logic [31:0] G2_LIMIT  = 32'd18454938;
	localparam logic signed [48:0] SMOOTH_OLD = 49'sd52429;
	localparam logic signed [48:0] SMOOTH_NEW = 49'sd13107;

	localparam int SQRT_STEPS   = 24;
	localparam int CORDIC_STEPS = 16;
	localparam int DIV_STEPS    = 25;
	localparam int QUEUE_DEPTH  = 2;

	localparam int INC_PR_W = 19;
	localparam int INC_Y_W  = 22;
	localparam int INC_I_W  = 23;

	typedef struct packed {
		logic [31:0]        r_yaw;
		logic [31:0]        r_roll;
		logic [31:0]        r_pitch;
		logic [31:0]        q_yaw;
		logic [31:0]        q_roll;
		logic [31:0]        q_pitch;
		logic signed [15:0] yaw_rate_offset;
		logic               filter_mode;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] yaw_rate_est;
		logic signed [15:0] accel_z;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_x;
		logic signed [15:0] rate_z;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_x;
	} sample_t;

	// One classified sample as the back end needs it
	typedef struct packed {
		logic signed [INC_I_W-1:0]  inc_i;
		logic signed [INC_Y_W-1:0]  inc_y;
		logic signed [INC_PR_W-1:0] inc_r;
		logic signed [INC_PR_W-1:0] inc_p;
		logic [31:0]                sum3;
		logic [31:0]                den_r;
		logic [31:0]                den_p;
		logic signed [15:0]         ax;
		logic signed [15:0]         ay;
	} item_t;

	function automatic logic signed [24:0] atan_lut(input logic [3:0] i);
		logic signed [24:0] v;
		case (i)
			4'd0: v = 25'sd2949120;
			4'd1: v = 25'sd1740967;
			4'd2: v = 25'sd919879;
			4'd3: v = 25'sd466945;
			4'd4: v = 25'sd234379;
			4'd5: v = 25'sd117304;
			4'd6: v = 25'sd58666;
			4'd7: v = 25'sd29335;
			4'd8: v = 25'sd14668;
			4'd9: v = 25'sd7334;
			4'd10: v = 25'sd3667;
			4'd11: v = 25'sd1833;
			4'd12: v = 25'sd917;
			4'd13: v = 25'sd458;
			4'd14: v = 25'sd229;
			4'd15: v = 25'sd115;
			default: v = 25'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/itkf_front.sv -----
// ----------------------------------------------------------------------------
// itkf_front: sample intake
// Registers one sample, forms the accelerometer squares and the rounded angle
// increments, and pushes the result into the work queue.
// ----------------------------------------------------------------------------
module itkf_front import itkf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] yaw_rate_offset,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [111:0]       s_tdata,
	output logic               push_valid,
	input  logic               push_ready,
	output item_t              push_item
);

	logic    valid_s1;
	sample_t smp_s1;

	logic signed [35:0] mp_x, mp_y;
	logic signed [38:0] my;
	logic signed [16:0] dz;
	logic signed [39:0] mi;
	logic signed [31:0] xx, yy, zz;

	assign s_tready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			smp_s1 <= sample_t'(s_tdata);
		end
	end

	always_comb begin
		mp_x = smp_s1.rate_x * DT_GAIN;
		mp_y = smp_s1.rate_y * DT_GAIN;
		my   = smp_s1.yaw_rate_est * YAW_DT_GAIN;
		dz   = 17'(smp_s1.rate_z) - 17'(yaw_rate_offset);
		mi   = dz * YAW_DT_GAIN;
		xx   = smp_s1.accel_x * smp_s1.accel_x;
		yy   = smp_s1.accel_y * smp_s1.accel_y;
		zz   = smp_s1.accel_z * smp_s1.accel_z;

		push_item.inc_p = INC_PR_W'((mp_x + 36'sd32768) >>> 16);
		push_item.inc_r = INC_PR_W'((mp_y + 36'sd32768) >>> 16);
		push_item.inc_y = INC_Y_W'((my + 39'sd32768) >>> 16);
		push_item.inc_i = INC_I_W'((mi + 40'sd32768) >>> 16);
		push_item.den_p = xx + zz;
		push_item.den_r = yy + zz;
		push_item.sum3  = xx + yy + zz;
		push_item.ax    = smp_s1.accel_x;
		push_item.ay    = smp_s1.accel_y;
	end

endmodule

// ----- hw/rtl/itkf_queue.sv -----
// ----------------------------------------------------------------------------
// itkf_queue: work queue
// Short FIFO between the intake and the filter sequencer.
// ----------------------------------------------------------------------------
module itkf_queue import itkf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop,
	output item_t pop_item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

// ----- hw/rtl/itkf_back.sv -----
// ----------------------------------------------------------------------------
// itkf_back: filter sequencer
// Runs the square roots, CORDIC, gain divisions (Kalman mode only) and state
// updates for one work item at a time and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module itkf_back import itkf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        item_valid,
	output logic        item_pop,
	input  item_t       item,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SQRT   = 4'd1;
	localparam logic [3:0] ST_CORDIC = 4'd2;
	localparam logic [3:0] ST_PRED   = 4'd3;
	localparam logic [3:0] ST_DIV    = 4'd4;
	localparam logic [3:0] ST_MUL    = 4'd5;
	localparam logic [3:0] ST_UPD    = 4'd6;
	localparam logic [3:0] ST_SMA    = 4'd7;
	localparam logic [3:0] ST_SMB    = 4'd8;
	localparam logic [3:0] ST_OUT    = 4'd9;

	logic [3:0] state_q;
	logic [4:0] cnt_q;
	item_t      ent_q;

	// Square root and CORDIC lanes: 0 pitch, 1 roll
	logic [47:0]        rad_q  [2];
	logic [25:0]        rem_q  [2];
	logic [23:0]        root_q [2];
	logic signed [27:0] cx_q   [2];
	logic signed [27:0] cy_q   [2];
	logic signed [24:0] cz_q   [2];
	logic               zero_q [2];

	// Filter lanes: 0 pitch, 1 roll, 2 yaw
	logic signed [31:0] est_q   [3];
	logic [31:0]        var_q   [3];
	logic signed [31:0] prior_q [3];
	logic signed [31:0] meas_q  [3];
	logic [31:0]        p_q     [3];
	logic [32:0]        den_q   [3];
	logic [33:0]        drem_q  [3];
	logic [24:0]        k_q     [3];
	logic signed [57:0] prod_q  [3];
	logic [56:0]        vprod_q [3];
	logic signed [31:0] yint_q;
	logic signed [31:0] smooth_q;
	logic signed [48:0] sacc_q;

	logic        m_tvalid_q;
	logic [95:0] m_tdata_q;

	logic [27:0]        st     [2];
	logic [27:0]        strial [2];
	logic               sge    [2];
	logic [25:0]        rem_n  [2];
	logic [23:0]        root_n [2];
	logic signed [27:0] cdx    [2];
	logic signed [27:0] cdy    [2];
	logic signed [27:0] cx_n   [2];
	logic signed [27:0] cy_n   [2];
	logic signed [24:0] cz_n   [2];
	logic signed [24:0] atan_v;
	logic [33:0]        dt     [3];
	logic               dge    [3];
	logic signed [32:0] diff   [3];
	logic signed [57:0] prod_n [3];
	logic [56:0]        vprod_n [3];
	logic signed [34:0] rs     [3];
	logic signed [31:0] upd_n  [3];
	logic signed [31:0] prior_n [3];
	logic [32:0]        psum   [3];
	logic [31:0]        p_n    [3];
	logic signed [31:0] yint_n;
	logic signed [15:0] num    [2];
	logic [31:0]        den_in [2];
	logic [31:0]        q_sel  [3];
	logic [31:0]        r_sel  [3];
	logic signed [31:0] inc_sel [3];
	logic               kalman;
	logic               out_free;

	assign kalman   = cfg.filter_mode == MODE_KALMAN;
	assign out_free = !m_tvalid_q || m_tready;
	assign item_pop = (state_q == ST_IDLE) && item_valid;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		num[0]     = ent_q.ay;
		num[1]     = ent_q.ax;
		den_in[0]  = item.den_p;
		den_in[1]  = item.den_r;
		q_sel[0]   = cfg.q_pitch;
		q_sel[1]   = cfg.q_roll;
		q_sel[2]   = cfg.q_yaw;
		r_sel[0]   = cfg.r_pitch;
		r_sel[1]   = cfg.r_roll;
		r_sel[2]   = cfg.r_yaw;
		inc_sel[0] = 32'(ent_q.inc_p);
		inc_sel[1] = 32'(ent_q.inc_r);
		inc_sel[2] = 32'(ent_q.inc_y);
		yint_n     = sat32(64'(yint_q) + 64'(ent_q.inc_i));
		atan_v     = atan_lut(cnt_q[3:0]);

		for (int l = 0; l < 2; l++) begin
			// One result bit of the square root per cycle
			st[l]     = {rem_q[l], rad_q[l][47:46]};
			strial[l] = {2'b00, root_q[l], 2'b01};
			sge[l]    = st[l] >= strial[l];
			rem_n[l]  = sge[l] ? 26'(st[l] - strial[l]) : st[l][25:0];
			root_n[l] = {root_q[l][22:0], sge[l]};

			cdx[l] = cy_q[l] >>> cnt_q[3:0];
			cdy[l] = cx_q[l] >>> cnt_q[3:0];
			if (!cy_q[l][27]) begin
				cx_n[l] = cx_q[l] + cdx[l];
				cy_n[l] = cy_q[l] - cdy[l];
				cz_n[l] = cz_q[l] + atan_v;
			end else begin
				cx_n[l] = cx_q[l] - cdx[l];
				cy_n[l] = cy_q[l] + cdy[l];
				cz_n[l] = cz_q[l] - atan_v;
			end
		end

		for (int a = 0; a < 3; a++) begin
			prior_n[a] = sat32(64'(est_q[a]) + 64'(inc_sel[a]));
			psum[a]    = {1'b0, var_q[a]} + {1'b0, q_sel[a]};
			p_n[a]     = psum[a][32] ? 32'hFFFFFFFF : psum[a][31:0];

			// The dividend is p << 24; only its bit 24 (p[0]) is nonzero below the start.
			dt[a]  = {drem_q[a][32:0], (cnt_q == '0) ? p_q[a][0] : 1'b0};
			dge[a] = dt[a] >= {1'b0, den_q[a]};

			diff[a]    = 33'(meas_q[a]) - 33'(prior_q[a]);
			prod_n[a]  = $signed({1'b0, k_q[a]}) * diff[a];
			vprod_n[a] = (ONE_Q24 - k_q[a]) * p_q[a];
			rs[a]      = 35'((59'(prod_q[a]) + 59'sd8388608) >>> 24);
			upd_n[a]   = sat32(64'(prior_q[a]) + 64'(rs[a]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			yint_q     <= '0;
			smooth_q   <= '0;
			for (int a = 0; a < 3; a++) begin
				est_q[a] <= '0;
				var_q[a] <= '0;
				k_q[a]   <= '0;
			end
		end else begin
			// In the output state the valid flag is handled below.
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (cnt_q == 5'(SQRT_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_CORDIC;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CORDIC: begin
					if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
						state_q <= ST_PRED;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PRED: begin
					cnt_q <= '0;
					for (int a = 0; a < 2; a++) begin
						prior_q[a] <= prior_n[a];
					end
					if (kalman) begin
						prior_q[2] <= prior_n[2];
						yint_q     <= yint_n;
						for (int a = 0; a < 3; a++) begin
							p_q[a]    <= p_n[a];
							den_q[a]  <= {1'b0, p_n[a]} + {1'b0, r_sel[a]};
							drem_q[a] <= 34'(p_n[a][31:1]);
							k_q[a]    <= '0;
						end
						state_q <= ST_DIV;
					end else begin
						k_q[0]  <= (ent_q.sum3 >= G2_LIMIT) ? '0 : COMP_GAIN;
						k_q[1]  <= (ent_q.sum3 >= G2_LIMIT) ? '0 : COMP_GAIN;
						state_q <= ST_MUL;
					end
				end
				ST_DIV: begin
					for (int a = 0; a < 3; a++) begin
						drem_q[a] <= dge[a] ? dt[a] - {1'b0, den_q[a]} : dt[a];
						if (cnt_q == 5'(DIV_STEPS - 1) && den_q[a] == '0) begin
							k_q[a] <= '0;
						end else begin
							k_q[a] <= {k_q[a][23:0], dge[a]};
						end
					end
					if (cnt_q == 5'(DIV_STEPS - 1)) begin
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					est_q[0] <= upd_n[0];
					est_q[1] <= upd_n[1];
					if (kalman) begin
						est_q[2] <= upd_n[2];
						for (int a = 0; a < 3; a++) begin
							var_q[a] <= vprod_q[a][55:24];
						end
						state_q <= ST_SMA;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_SMA: begin
					state_q <= ST_SMB;
				end
				ST_SMB: begin
					smooth_q <= sat32(64'((sacc_q + 49'sd32768) >>> 16));
					state_q  <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers without reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					ent_q <= item;
					for (int l = 0; l < 2; l++) begin
						rad_q[l]  <= {den_in[l], 16'h0000};
						rem_q[l]  <= '0;
						root_q[l] <= '0;
					end
				end
			end
			ST_SQRT: begin
				for (int l = 0; l < 2; l++) begin
					rad_q[l]  <= {rad_q[l][45:0], 2'b00};
					rem_q[l]  <= rem_n[l];
					root_q[l] <= root_n[l];
					if (cnt_q == 5'(SQRT_STEPS - 1)) begin
						cx_q[l]   <= 28'(root_n[l]);
						cy_q[l]   <= 28'($signed({num[l], 8'h00}));
						cz_q[l]   <= '0;
						zero_q[l] <= (root_n[l] == '0) && (num[l] == '0);
					end
				end
			end
			ST_CORDIC: begin
				for (int l = 0; l < 2; l++) begin
					cx_q[l] <= cx_n[l];
					cy_q[l] <= cy_n[l];
					cz_q[l] <= cz_n[l];
				end
				if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
					meas_q[0] <= zero_q[0] ? '0 : 32'(cz_n[0]);
					meas_q[1] <= zero_q[1] ? '0 : -32'(cz_n[1]);
				end
			end
			ST_PRED: begin
				if (kalman) begin
					meas_q[2] <= yint_n;
				end
			end
			ST_MUL: begin
				for (int a = 0; a < 3; a++) begin
					prod_q[a]  <= prod_n[a];
					vprod_q[a] <= vprod_n[a];
				end
			end
			ST_SMA: begin
				sacc_q <= 49'(smooth_q) * SMOOTH_OLD + 49'(est_q[0]) * SMOOTH_NEW;
			end
			ST_OUT: begin
				if (out_free) begin
					m_tdata_q <= {est_q[2], est_q[1], kalman ? smooth_q : est_q[0]};
				end
			end
			default: begin
			end
		endcase
	end

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> m_tvalid_q)
		else $error("result word not presented after the output stage was loaded");

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (k_q[0] <= ONE_Q24 && k_q[1] <= ONE_Q24
		&& (!kalman || k_q[2] <= ONE_Q24)))
		else $error("filter gain exceeds one");

	a_var_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && kalman) |=> (var_q[0] <= $past(p_q[0])
		&& var_q[1] <= $past(p_q[1]) && var_q[2] <= $past(p_q[2])))
		else $error("posterior variance larger than predicted variance");

	a_cordic_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CORDIC) |-> (cnt_q < 5'(CORDIC_STEPS)))
		else $error("CORDIC iteration count out of range");

endmodule

// ----- hw/rtl/imu_tilt_kalman_filter_top.sv -----
// ----------------------------------------------------------------------------
// imu_tilt_kalman_filter_top: IMU pitch, roll and yaw estimator
// Scalar Kalman or complementary filter on accelerometer and gyro samples.
// ----------------------------------------------------------------------------
// The s_ channel takes one IMU sample per word, the m_ channel returns one
// word of pitch, roll and yaw angles (Q16.16 degrees) for every sample.
// Registers are to be written over the APB port only while the block is idle;
// the block itself does not enforce this, and pready is always high.
// An accepted sample passes an input register and a two-entry queue, then the
// sequencer runs a 24-step square root, a 16-step CORDIC, the prediction, a
// 25-step gain divider (Kalman mode only), the multiply and update steps, the
// pitch smoothing (Kalman mode only) and the output step. That sequencer works
// on one sample at a time and so sets the sustained rate.
// The intake keeps accepting samples until the queue is full, and the
// sequencer starts the next sample while a result word still waits on m_.
// When m_tready stays low the result waits in the output register and the
// sequencer stops at its final step; the queue then fills and s_tready drops.
// Reset clears all filter state to zero and loads the register defaults.
// ----------------------------------------------------------------------------
module imu_tilt_kalman_filter_top import itkf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z, yaw_rate_est
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // pitch_angle, roll_angle, yaw_angle
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;
	logic       push_valid, push_ready, item_valid, item_pop;
	item_t      push_item, head_item;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_mode     <= MODE_KALMAN;
			cfg_q.q_pitch         <= 32'd16777;
			cfg_q.q_roll          <= 32'd16777;
			cfg_q.q_yaw           <= 32'd167772;
			cfg_q.r_pitch         <= 32'd1677722;
			cfg_q.r_roll          <= 32'd1677722;
			cfg_q.r_yaw           <= 32'd1677722;
			cfg_q.yaw_rate_offset <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:       cfg_q.filter_mode     <= pwdata[0];
				REG_Q_PITCH:    cfg_q.q_pitch         <= pwdata;
				REG_Q_ROLL:     cfg_q.q_roll          <= pwdata;
				REG_Q_YAW:      cfg_q.q_yaw           <= pwdata;
				REG_R_PITCH:    cfg_q.r_pitch         <= pwdata;
				REG_R_ROLL:     cfg_q.r_roll          <= pwdata;
				REG_R_YAW:      cfg_q.r_yaw           <= pwdata;
				REG_YAW_OFFSET: cfg_q.yaw_rate_offset <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE:       prdata = 32'(cfg_q.filter_mode);
			REG_Q_PITCH:    prdata = cfg_q.q_pitch;
			REG_Q_ROLL:     prdata = cfg_q.q_roll;
			REG_Q_YAW:      prdata = cfg_q.q_yaw;
			REG_R_PITCH:    prdata = cfg_q.r_pitch;
			REG_R_ROLL:     prdata = cfg_q.r_roll;
			REG_R_YAW:      prdata = cfg_q.r_yaw;
			REG_YAW_OFFSET: prdata = 32'(cfg_q.yaw_rate_offset);
			default:        prdata = '0;
		endcase
	end

	itkf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.yaw_rate_offset (cfg_q.yaw_rate_offset),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.push_valid      (push_valid),
		.push_ready      (push_ready),
		.push_item       (push_item)
	);

	itkf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (item_valid),
		.pop        (item_pop),
		.pop_item   (head_item)
	);

	itkf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.item       (head_item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

// ----- tb/imu_tilt_kalman_filter_top_test.sv -----
// ----------------------------------------------------------------------------
// imu_tilt_kalman_filter_top_test: self-checking test of the tilt estimator
// Streams IMU samples with random gaps on both sides, predicts every angle
// word in the testbench and compares it with the word the block returns.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_tilt_kalman_filter_top_test;
	import itkf_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int DRAIN_CYCLES   = 200;

	typedef struct {
		logic signed [31:0] pitch;
		logic signed [31:0] roll;
		logic signed [31:0] yaw;
	} angles_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;   // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z, yaw_rate_est
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;   // pitch_angle, roll_angle, yaw_angle
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [4:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	imu_tilt_kalman_filter_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor copy of configuration and filter state
	logic               mdl_mode;
	logic [31:0]        mdl_q_p, mdl_q_r, mdl_q_y, mdl_r_p, mdl_r_r, mdl_r_y;
	logic signed [15:0] mdl_offset;
	logic signed [31:0] est_p, est_r, est_y, yaw_int, pitch_sm;
	logic [31:0]        var_p, var_r, var_y;

	sample_t sample_queue[$];
	angles_t angle_queue[$];
	int      error_count;
	int      idle_cycles;
	int      gap_count;
	int      stall_count;
	bit      timed_out;
	bit      in_taken;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint asr64(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Arctangent of num over sqrt(den_sq) in Q16.16 degrees, by CORDIC.
	function automatic longint tilt_atan(longint num, longint unsigned den_sq);
		longint x, y, z, dx, dy;
		x = longint'(int_sqrt(den_sq << 16));
		y = num * 256;
		z = 0;
		if (x == 0 && y == 0) return 0;
		for (int i = 0; i < 16; i++) begin
			dx = asr64(y, i);
			dy = asr64(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += longint'(atan_lut(i[3:0]));
			end else begin
				x -= dx; y += dy; z -= longint'(atan_lut(i[3:0]));
			end
		end
		return z;
	endfunction

	function automatic logic signed [31:0] correct_angle(logic signed [31:0] prior,
			longint meas, longint unsigned k);
		longint diff;
		diff = meas - longint'(prior);
		return 32'(clamp32(longint'(prior) + round_shift(longint'(k) * diff, 24)));
	endfunction

	task automatic kalman_update(inout logic signed [31:0] est, inout logic [31:0] var_x,
			input longint inc, input longint meas, input logic [31:0] q, input logic [31:0] r);
		logic signed [31:0] prior;
		longint unsigned p, den, k;
		prior = 32'(clamp32(longint'(est) + inc));
		p = longint'(var_x) + longint'(q);
		if (p > 64'hFFFFFFFF) p = 64'hFFFFFFFF;
		den = p + longint'(r);
		k = (den != 0) ? (p << 24) / den : 0;
		est = correct_angle(prior, meas, k);
		var_x = 32'(((64'd16777216 - k) * p) >> 24);
	endtask

	task automatic predict_angles(input sample_t s);
		longint ax, ay, az, inc_p, inc_r, inc_y, inc_i, meas_p, meas_r, sm;
		longint unsigned xx, yy, zz, k;
		angles_t a;
		ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
		xx = ax * ax; yy = ay * ay; zz = az * az;
		meas_p = tilt_atan(ay, xx + zz);
		meas_r = -tilt_atan(ax, yy + zz);
		inc_p = round_shift(longint'(s.rate_x) * 456340, 16);
		inc_r = round_shift(longint'(s.rate_y) * 456340, 16);
		if (mdl_mode == MODE_KALMAN) begin
			inc_y = round_shift(longint'(s.yaw_rate_est) * 2684355, 16);
			inc_i = round_shift((longint'(s.rate_z) - longint'(mdl_offset)) * 2684355, 16);
			yaw_int = 32'(clamp32(longint'(yaw_int) + inc_i));
			kalman_update(est_p, var_p, inc_p, meas_p, mdl_q_p, mdl_r_p);
			kalman_update(est_r, var_r, inc_r, meas_r, mdl_q_r, mdl_r_r);
			kalman_update(est_y, var_y, inc_y, longint'(yaw_int), mdl_q_y, mdl_r_y);
			sm = round_shift(longint'(pitch_sm) * 52429 + longint'(est_p) * 13107, 16);
			pitch_sm = 32'(clamp32(sm));
			a.pitch = pitch_sm;
		end else begin
			k = (xx + yy + zz >= 64'd18454938) ? 0 : 2516582;
			est_p = correct_angle(32'(clamp32(longint'(est_p) + inc_p)), meas_p, k);
			est_r = correct_angle(32'(clamp32(longint'(est_r) + inc_r)), meas_r, k);
			a.pitch = est_p;
		end
		a.roll = est_r;
		a.yaw = est_y;
		angle_queue.push_back(a);
	endtask

	function automatic int random_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
		return $urandom_range(0, 4);
	endfunction

	// Driver: one word at a time from the pending queue, new data at the falling edge.
	// Acceptance is taken from the flag the monitor samples at the rising edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				predict_angles(sample_queue.pop_front());
				gap_count = random_gap();
			end
			if (!s_tvalid || in_taken) begin
				if (gap_count > 0) begin
					gap_count--;
					s_tvalid <= 1'b0;
				end else if (sample_queue.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= sample_queue[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (stall_count > 0) begin
				stall_count--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_count = random_gap();
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	// Monitor: checks every accepted result word against the oldest prediction.
	always @(posedge clk) begin
		angles_t want;
		if (arst_n) begin
			in_taken = s_tvalid && s_tready;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (m_tvalid && m_tready) begin
				if (angle_queue.size() == 0) begin
					report_mismatch("unexpected word", m_tdata[31:0], 32'h0);
				end else begin
					want = angle_queue.pop_front();
					if (m_tdata[31:0] !== want.pitch)
						report_mismatch("pitch", m_tdata[31:0], want.pitch);
					if (m_tdata[63:32] !== want.roll)
						report_mismatch("roll", m_tdata[63:32], want.roll);
					if (m_tdata[95:64] !== want.yaw)
						report_mismatch("yaw", m_tdata[95:64], want.yaw);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {index, 2'b00}; pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (index)
			REG_MODE:       mdl_mode = value[0];
			REG_Q_PITCH:    mdl_q_p = value;
			REG_Q_ROLL:     mdl_q_r = value;
			REG_Q_YAW:      mdl_q_y = value;
			REG_R_PITCH:    mdl_r_p = value;
			REG_R_ROLL:     mdl_r_r = value;
			REG_R_YAW:      mdl_r_y = value;
			REG_YAW_OFFSET: mdl_offset = value[15:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (sample_queue.size() != 0 || s_tvalid || angle_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 8192)) - 4096);
		endcase
	endfunction

	function automatic logic [15:0] rand_rate();
		if ($urandom_range(0, 4) == 0) return 16'($urandom);
		return 16'($signed($urandom_range(0, 2000)) - 1000);
	endfunction

	task automatic push_sample(input logic [15:0] rx, ry, rz, ax, ay, az, yr);
		sample_t s;
		s.rate_x = rx; s.rate_y = ry; s.rate_z = rz;
		s.accel_x = ax; s.accel_y = ay; s.accel_z = az; s.yaw_rate_est = yr;
		sample_queue.push_back(s);
	endtask

	task automatic random_samples(input int n);
		for (int i = 0; i < n; i++)
			push_sample(rand_rate(), rand_rate(), rand_rate(), rand_axis(), rand_axis(),
				rand_axis(), rand_rate());
	endtask

	function automatic logic [31:0] rand_var();
		case ($urandom_range(0, 4))
			0: return 32'h0;
			1: return 32'hFFFFFFFF;
			default: return $urandom_range(0, 32'h04000000);
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		error_count = 0; idle_cycles = 0; gap_count = 0; stall_count = 0;
		timed_out = 1'b0; in_taken = 1'b0;
		mdl_mode = MODE_KALMAN;
		mdl_q_p = 16777; mdl_q_r = 16777; mdl_q_y = 167772;
		mdl_r_p = 1677722; mdl_r_r = 1677722; mdl_r_y = 1677722; mdl_offset = 0;
		est_p = 0; est_r = 0; est_y = 0; yaw_int = 0; pitch_sm = 0;
		var_p = 0; var_r = 0; var_y = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, zero denominators, both modes.
		push_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
		push_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h1000, 16'h0, 16'h0);
		push_sample(16'h0, 16'h0, 16'h0, 16'hF000, 16'h0, 16'h0, 16'h0);
		push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		push_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		push_sample(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0, 16'h0, 16'h1000, 16'h0001);
		push_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
		push_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
		wait_idle();
		write_reg(REG_MODE, 32'hFFFFFFFE);
		write_reg(REG_Q_PITCH, 32'h0); write_reg(REG_R_PITCH, 32'h0);
		write_reg(REG_Q_ROLL, 32'hFFFFFFFF); write_reg(REG_R_ROLL, 32'hFFFFFFFF);
		write_reg(REG_Q_YAW, 32'hFFFFFFFF); write_reg(REG_R_YAW, 32'h0);
		write_reg(REG_YAW_OFFSET, 32'h00008000);
		push_sample(16'h0, 16'h0, 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h8000);
		push_sample(16'h0, 16'h0, 16'h7FFF, 16'h0, 16'h1000, 16'h0, 16'h7FFF);
		push_sample(16'h100, 16'h100, 16'h0, 16'h0, 16'h0, 16'h1000, 16'h0);
		wait_idle();
		write_reg(REG_MODE, 32'h1);
		push_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h1000, 16'h0);
		push_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h10C8, 16'h0);
		push_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h10CA, 16'h0);
		push_sample(16'h7FFF, 16'h8000, 16'h0, 16'h800, 16'hF800, 16'h800, 16'h0);
		push_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
		wait_idle();

		// Random phases with changing settings, extremes among them.
		for (int phase = 0; phase < 7; phase++) begin
			write_reg(REG_MODE, (phase % 3 == 2) ? 32'h1 : 32'h0);
			write_reg(REG_Q_PITCH, rand_var()); write_reg(REG_Q_ROLL, rand_var());
			write_reg(REG_Q_YAW, rand_var()); write_reg(REG_R_PITCH, rand_var());
			write_reg(REG_R_ROLL, rand_var()); write_reg(REG_R_YAW, rand_var());
			write_reg(REG_YAW_OFFSET, $urandom);
			random_samples(245);
			wait_idle();
		end

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/itkf_pkg.sv
hw/rtl/itkf_front.sv
hw/rtl/itkf_queue.sv
hw/rtl/itkf_back.sv
hw/rtl/imu_tilt_kalman_filter_top.sv
tb/imu_tilt_kalman_filter_top_test.sv
